// ===== design/bom_sniff_utf16le_to_utf8_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the BOM sniffer / UTF-16LE transcoder
// Helpers for the concurrent checks in the job queue (bomsniff_queue).
// ----------------------------------------------------------------------------
`ifndef BOM_SNIFF_UTF16LE_TO_UTF8_DEFINES_SVH
`define BOM_SNIFF_UTF16LE_TO_UTF8_DEFINES_SVH

// same-cycle implication
`define BOMSNIFF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOMSNIFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bomsniff_pkg.sv =====
// ----------------------------------------------------------------------------
// bomsniff_pkg
// Types and constants shared by the BOM sniffer front, job queue and back.
// ----------------------------------------------------------------------------
package bomsniff_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BIG_ENDIAN = 3'd1,
    ERR_ODD_LENGTH = 3'd2,
    ERR_TRAIL_HIGH = 3'd3,
    ERR_BAD_PAIR   = 3'd4,
    ERR_INVALID_CP = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    JOB_RAW,
    JOB_CP,
    JOB_MARK
  } job_kind_t;

  // RAW: data holds up to three bytes, first byte lowest; cnt is 1..3
  // CP:  data[20:0] holds a code point
  // MARK: bare end or error item
  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] data;
    logic [1:0]  cnt;
    logic        last;
    err_code_t   err;
  } job_t;

endpackage

// ===== design/bomsniff_front.sv =====
// ----------------------------------------------------------------------------
// bomsniff_front
// Accepts input bytes, tracks the prefix and UTF-16 state, and turns each
// byte into at most one job for the back end.
// ----------------------------------------------------------------------------
module bomsniff_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] in_byte
  input  logic                s_tlast,
  input  logic                q_full,
  output logic                push,
  output bomsniff_pkg::job_t  job
);
  import bomsniff_pkg::*;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_PASS,
    PH_UTF16,
    PH_DRAIN
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  prefix_count, prefix_count_next;
  logic        unit_half_seen, unit_half_seen_next;
  logic        surrogate_pending, surrogate_pending_next;
  logic [7:0]  prefix_hold, prefix_hold_next;
  logic [7:0]  unit_low_hold, unit_low_hold_next;
  logic [9:0]  high_surrogate_hold, high_surrogate_hold_next;

  logic        accept;
  logic        produce;
  logic [7:0]  b;
  logic        last;
  logic [15:0] unit;
  logic        unit_is_high;
  logic        unit_is_low;
  logic [20:0] cp_pair;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && produce;
  assign b        = s_tdata;
  assign last     = s_tlast;

  assign unit         = {b, unit_low_hold};
  assign unit_is_high = (unit >= SURR_HIGH_FIRST) && (unit <= SURR_HIGH_LAST);
  assign unit_is_low  = (unit >= SURR_LOW_FIRST) && (unit <= SURR_LOW_LAST);
  assign cp_pair      = SUPP_BASE + {1'b0, high_surrogate_hold, unit[9:0]};

  always_comb begin
    phase_next               = phase;
    prefix_count_next        = prefix_count;
    unit_half_seen_next      = unit_half_seen;
    surrogate_pending_next   = surrogate_pending;
    prefix_hold_next         = prefix_hold;
    unit_low_hold_next       = unit_low_hold;
    high_surrogate_hold_next = high_surrogate_hold;
    produce                  = 1'b0;
    job.kind                 = JOB_RAW;
    job.data                 = '0;
    job.cnt                  = 2'd1;
    job.last                 = last;
    job.err                  = ERR_NONE;

    case (phase)
      PH_DRAIN: begin
      end
      PH_PREFIX: begin
        case (prefix_count)
          2'd0: begin
            prefix_hold_next  = b;
            prefix_count_next = 2'd1;
            if (last) begin
              produce  = 1'b1;
              job.data = {16'h0000, b};
            end
          end
          2'd1: begin
            if (prefix_hold == BYTE_EF && b == BYTE_BB && !last) begin
              prefix_count_next = 2'd2;
            end else if (prefix_hold == BYTE_FE && b == BYTE_FF) begin
              produce    = 1'b1;
              job.kind   = JOB_MARK;
              job.last   = 1'b1;
              job.err    = ERR_BIG_ENDIAN;
              phase_next = PH_DRAIN;
            end else if (prefix_hold == BYTE_FF && b == BYTE_FE) begin
              if (last) begin
                produce  = 1'b1;
                job.kind = JOB_MARK;
              end
              phase_next = PH_UTF16;
            end else begin
              produce    = 1'b1;
              job.data   = {8'h00, b, prefix_hold};
              job.cnt    = 2'd2;
              phase_next = PH_PASS;
            end
          end
          default: begin
            produce    = !(b == BYTE_BF) || last;
            phase_next = PH_PASS;
            if (b == BYTE_BF) begin
              job.kind = JOB_MARK;
            end else begin
              job.data = {b, BYTE_BB, BYTE_EF};
              job.cnt  = 2'd3;
            end
          end
        endcase
      end
      PH_PASS: begin
        produce  = 1'b1;
        job.data = {16'h0000, b};
      end
      default: begin
        if (!unit_half_seen) begin
          if (last) begin
            produce  = 1'b1;
            job.kind = JOB_MARK;
            job.err  = ERR_ODD_LENGTH;
          end else begin
            unit_low_hold_next  = b;
            unit_half_seen_next = 1'b1;
          end
        end else begin
          unit_half_seen_next = 1'b0;
          produce             = 1'b1;
          if (surrogate_pending) begin
            if (!unit_is_low) begin
              job.kind   = JOB_MARK;
              job.err    = ERR_BAD_PAIR;
              phase_next = PH_DRAIN;
            end else begin
              surrogate_pending_next = 1'b0;
              job.kind               = JOB_CP;
              job.data               = {3'b000, cp_pair};
            end
          end else if (unit_is_high) begin
            if (last) begin
              job.kind = JOB_MARK;
              job.err  = ERR_TRAIL_HIGH;
            end else begin
              produce                  = 1'b0;
              high_surrogate_hold_next = unit[9:0];
              surrogate_pending_next   = 1'b1;
            end
          end else if (unit_is_low) begin
            job.kind   = JOB_MARK;
            job.err    = ERR_INVALID_CP;
            phase_next = PH_DRAIN;
          end else begin
            job.kind = JOB_CP;
            job.data = {8'h00, unit};
          end
        end
      end
    endcase

    if (job.kind == JOB_MARK) begin
      job.last = 1'b1;
    end

    // end of stream: back to sniffing the next prefix
    if (last) begin
      phase_next             = PH_PREFIX;
      prefix_count_next      = 2'd0;
      unit_half_seen_next    = 1'b0;
      surrogate_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_PREFIX;
      prefix_count      <= 2'd0;
      unit_half_seen    <= 1'b0;
      surrogate_pending <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      prefix_count      <= prefix_count_next;
      unit_half_seen    <= unit_half_seen_next;
      surrogate_pending <= surrogate_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_hold         <= prefix_hold_next;
      unit_low_hold       <= unit_low_hold_next;
      high_surrogate_hold <= high_surrogate_hold_next;
    end
  end

endmodule

// ===== design/bomsniff_queue.sv =====
// ----------------------------------------------------------------------------
// bomsniff_queue
// Small job FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`include "bom_sniff_utf16le_to_utf8_defines.svh"

module bomsniff_queue #(
  parameter int DEPTH = bomsniff_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bomsniff_pkg::job_t  push_job,
  input  logic                pop,
  output bomsniff_pkg::job_t  head,
  output logic                full,
  output logic                empty
);
  import bomsniff_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `BOMSNIFF_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "job pushed into full queue")
  `BOMSNIFF_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty, "job popped from empty queue")
  `BOMSNIFF_ASSERT_NOW(a_ptrs_empty, clk, rst, empty, wr_ptr == rd_ptr, "pointers apart while empty")
  `BOMSNIFF_ASSERT_NEXT(a_count_hold, clk, rst, !push && !pop, $stable(count), "count moved idle")

endmodule

// ===== design/bomsniff_back.sv =====
// ----------------------------------------------------------------------------
// bomsniff_back
// Expands one job into its UTF-8 bytes, raw bytes or end marker and sends
// them out one item per cycle while m_tready is high, from registered job state.
// ----------------------------------------------------------------------------
module bomsniff_back (
  input  logic                clk,
  input  logic                rst,
  input  bomsniff_pkg::job_t  head,
  input  logic                empty,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic [3:0]          m_tuser,   // [0] out_valid, [3:1] error_code
  output logic                m_tlast
);
  import bomsniff_pkg::*;

  logic [7:0] cur_bytes [4];
  logic [2:0] cur_n;
  logic       cur_last;
  logic       cur_mark;
  err_code_t  cur_err;
  logic [1:0] idx;
  logic       active;

  logic [7:0] ld_bytes [4];
  logic [2:0] ld_n;
  logic       at_end;
  logic       advance;

  // UTF-8 encoding of a code point, raw bytes passed as they are, or a zero byte for a marker
  always_comb begin
    logic [20:0] cp;
    cp = head.data[20:0];
    ld_bytes[0] = head.data[7:0];
    ld_bytes[1] = head.data[15:8];
    ld_bytes[2] = head.data[23:16];
    ld_bytes[3] = 8'h00;
    ld_n        = {1'b0, head.cnt};
    case (head.kind)
      JOB_CP: begin
        if (cp <= 21'h7F) begin
          ld_bytes[0] = {1'b0, cp[6:0]};
          ld_n        = 3'd1;
        end else if (cp <= 21'h7FF) begin
          ld_bytes[0] = {3'b110, cp[10:6]};
          ld_bytes[1] = {2'b10, cp[5:0]};
          ld_n        = 3'd2;
        end else if (cp <= 21'hFFFF) begin
          ld_bytes[0] = {4'b1110, cp[15:12]};
          ld_bytes[1] = {2'b10, cp[11:6]};
          ld_bytes[2] = {2'b10, cp[5:0]};
          ld_n        = 3'd3;
        end else begin
          ld_bytes[0] = {5'b11110, cp[20:18]};
          ld_bytes[1] = {2'b10, cp[17:12]};
          ld_bytes[2] = {2'b10, cp[11:6]};
          ld_bytes[3] = {2'b10, cp[5:0]};
          ld_n        = 3'd4;
        end
      end
      JOB_MARK: begin
        ld_bytes[0] = 8'h00;
        ld_n        = 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign at_end   = (({1'b0, idx} + 3'd1) == cur_n);
  assign advance  = !active || (m_tready && at_end);
  assign pop      = advance && !empty;

  assign m_tvalid = active;
  assign m_tdata  = cur_bytes[idx];
  assign m_tuser  = {cur_err, !cur_mark};
  assign m_tlast  = cur_last && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 2'd0;
    end else if (advance) begin
      active <= !empty;
      idx    <= 2'd0;
    end else if (m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bytes <= ld_bytes;
      cur_n     <= ld_n;
      cur_last  <= head.last;
      cur_mark  <= (head.kind == JOB_MARK);
      cur_err   <= head.err;
    end
  end

endmodule

// ===== design/bom_sniff_utf16le_to_utf8.sv =====
// ----------------------------------------------------------------------------
// bom_sniff_utf16le_to_utf8
// Byte-order-mark sniffer with UTF-16LE to UTF-8 transcoding.
// ----------------------------------------------------------------------------
// The input side takes one byte per cycle and never waits on the output
// side unless the job queue (QUEUE_DEPTH jobs) is full. A pass-through byte
// leaves as one output item; in UTF-16LE mode two input bytes give one to
// three output items and a surrogate pair (four input bytes) gives four. The
// back end sends one item per cycle while m_tready is high, so the output
// item rate of the back end limits the sustained input rate in UTF-16LE
// mode, most for characters from U+0800 to U+FFFF (three output items per
// two input bytes). An error or an empty stream ends with a single item
// with out_valid low and tlast high; after an error the rest of the stream
// is dropped up to its tlast.
module bom_sniff_utf16le_to_utf8 #(
  parameter int QUEUE_DEPTH = bomsniff_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [3:0] m_tuser,   // [0] out_valid, [3:1] error_code
  output logic       m_tlast    // out_last
);
  import bomsniff_pkg::*;

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  bomsniff_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  bomsniff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bomsniff_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== test/tb_bom_sniff_utf16le_to_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bom_sniff_utf16le_to_utf8
// Self-checking bench for the byte-order-mark sniffer and UTF-16LE transcoder.
// A queue of byte streams drives the input side. Directed streams come first,
// then random streams with varied idling on both sides. Each accepted byte
// runs through a behavioral transcoder that queues the UTF-8 items it should
// produce. The monitor checks every output item in order against that queue.
// ----------------------------------------------------------------------------
module tb_bom_sniff_utf16le_to_utf8;
  import bomsniff_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int ITEMS_PER_PHASE  = 45;
  localparam int HOLD_CYCLES      = 400;
  localparam int TAIL_CYCLES      = 32;
  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] LEAD4    = 8'hF0;
  localparam logic [7:0] CONT     = 8'h80;

  typedef enum logic [1:0] {
    ST_SNIFF,
    ST_PASS,
    ST_UTF16,
    ST_DRAIN
  } sniff_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    err_code_t  err;
  } utf8_item_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  bom_sniff_utf16le_to_utf8 u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  byte_item_t byte_stim[$];
  logic [7:0] strm[$];
  utf8_item_t utf8_expected[$];
  utf8_item_t step_res[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  logic hold_go       = 1'b0;
  logic hold          = 1'b0;
  int fails           = 0;
  int cycles          = 0;
  int streams_sent    = 0;
  int bytes_in        = 0;
  int items_checked   = 0;
  int error_ends      = 0;

  // transcoder state
  sniff_state_t st;
  logic [7:0]   lead0, lead1;
  logic [1:0]   lead_cnt;
  logic [7:0]   unit_lo;
  logic         half;
  logic [9:0]   high_bits;
  logic         pair_pend;

  task automatic restart_stream();
    st        = ST_SNIFF;
    lead_cnt  = 2'd0;
    half      = 1'b0;
    pair_pend = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    utf8_item_t it;
    it = '{data: b, valid: 1'b1, last: 1'b0, err: ERR_NONE};
    step_res = {step_res, it};
  endtask

  task automatic add_mark(input err_code_t code);
    utf8_item_t it;
    it = '{data: 8'h00, valid: 1'b0, last: 1'b1, err: code};
    step_res = {step_res, it};
  endtask

  task automatic abort_stream(input err_code_t code, input logic last);
    if (last) restart_stream();
    else st = ST_DRAIN;
    add_mark(code);
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      add_byte(LEAD2 | {3'b0, cp[10:6]});
      add_byte(CONT | {2'b0, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      add_byte(LEAD3 | {4'b0, cp[15:12]});
      add_byte(CONT | {2'b0, cp[11:6]});
      add_byte(CONT | {2'b0, cp[5:0]});
    end else begin
      add_byte(LEAD4 | {5'b0, cp[20:18]});
      add_byte(CONT | {2'b0, cp[17:12]});
      add_byte(CONT | {2'b0, cp[11:6]});
      add_byte(CONT | {2'b0, cp[5:0]});
    end
  endtask

  task automatic sniff_byte(input logic [7:0] b, input logic last);
    if (lead_cnt == 2'd0) begin
      lead0    = b;
      lead_cnt = 2'd1;
      if (last) add_byte(b);
    end else if (lead_cnt == 2'd1) begin
      if (lead0 == BYTE_EF && b == BYTE_BB && !last) begin
        lead1    = b;
        lead_cnt = 2'd2;
      end else if (lead0 == BYTE_FE && b == BYTE_FF) begin
        abort_stream(ERR_BIG_ENDIAN, last);
      end else if (lead0 == BYTE_FF && b == BYTE_FE) begin
        if (last) add_mark(ERR_NONE);
        else st = ST_UTF16;
      end else begin
        add_byte(lead0);
        add_byte(b);
        st = ST_PASS;
      end
    end else begin
      st = ST_PASS;
      if (b == BYTE_BF) begin
        if (last) add_mark(ERR_NONE);
      end else begin
        add_byte(lead0);
        add_byte(lead1);
        add_byte(b);
      end
    end
  endtask

  task automatic utf16_byte(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    logic [20:0] cp;
    if (!half) begin
      if (last) begin
        abort_stream(ERR_ODD_LENGTH, 1'b1);
      end else begin
        unit_lo = b;
        half    = 1'b1;
      end
      return;
    end
    half = 1'b0;
    unit = {b, unit_lo};
    if (pair_pend) begin
      if (unit < SURR_LOW_FIRST || unit > SURR_LOW_LAST) begin
        abort_stream(ERR_BAD_PAIR, last);
      end else begin
        pair_pend = 1'b0;
        cp = SUPP_BASE + {1'b0, high_bits, 10'b0} + {11'b0, unit[9:0]};
        add_code_point(cp);
      end
    end else if (unit >= SURR_HIGH_FIRST && unit <= SURR_HIGH_LAST) begin
      if (last) begin
        abort_stream(ERR_TRAIL_HIGH, 1'b1);
      end else begin
        high_bits = unit[9:0];
        pair_pend = 1'b1;
      end
    end else if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
      abort_stream(ERR_INVALID_CP, last);
    end else begin
      add_code_point({5'b0, unit});
    end
  endtask

  // one accepted input byte -> expected output items
  task automatic transcode_byte(input logic [7:0] b, input logic last);
    step_res.delete();
    if (st == ST_DRAIN) begin
      if (last) restart_stream();
      return;
    end
    case (st)
      ST_SNIFF: sniff_byte(b, last);
      ST_PASS:  add_byte(b);
      default:  utf16_byte(b, last);
    endcase
    if (last && st != ST_SNIFF && st != ST_DRAIN) begin
      if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
      else add_mark(ERR_NONE);
      restart_stream();
    end else if (last && st == ST_SNIFF && step_res.size() > 0) begin
      step_res[step_res.size()-1].last = 1'b1;
      restart_stream();
    end
    utf8_expected = {utf8_expected, step_res};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        transcode_byte(s_tdata, s_tlast);
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_stim.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_stim[0].data;
          s_tlast  <= byte_stim[0].last;
          void'(byte_stim.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    utf8_item_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (utf8_expected.size() == 0) begin
          $error("output item with nothing expected: data %0h user %0h last %0b",
                 m_tdata, m_tuser, m_tlast);
          fails++;
        end else begin
          e = utf8_expected.pop_front();
          items_checked++;
          if (m_tdata !== e.data) begin
            $error("out_byte: expected %0h, got %0h", e.data, m_tdata);
            fails++;
          end
          if (m_tuser[0] !== e.valid) begin
            $error("out_valid: expected %0b, got %0b", e.valid, m_tuser[0]);
            fails++;
          end
          if (m_tlast !== e.last) begin
            $error("out_last: expected %0b, got %0b", e.last, m_tlast);
            fails++;
          end
          if (m_tuser[3:1] !== e.err) begin
            $error("error_code: expected %0d, got %0d", e.err, m_tuser[3:1]);
            fails++;
          end
          if (!e.valid && e.err != ERR_NONE) error_ends++;
        end
      end
      m_tready <= !hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the job queue fills and input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic end_stream();
    byte_item_t it;
    foreach (strm[i]) begin
      it = '{data: strm[i], last: i == strm.size() - 1};
      byte_stim = {byte_stim, it};
    end
    streams_sent++;
    strm.delete();
  endtask

  task automatic push_unit(input logic [15:0] u);
    strm = {strm, u[7:0], u[15:8]};
  endtask

  task automatic push_random_cp();
    logic [20:0] cp;
    logic [20:0] off;
    case ($urandom_range(3))
      0: push_unit(16'($urandom_range(16'h7F)));
      1: push_unit(16'($urandom_range(16'h80, 16'h7FF)));
      2: begin
        cp = 21'($urandom_range(16'h800, 16'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
        push_unit(cp[15:0]);
      end
      default: begin
        cp  = 21'($urandom_range(21'h10000, 21'h10FFFF));
        off = cp - SUPP_BASE;
        push_unit(SURR_HIGH_FIRST | {6'b0, off[19:10]});
        push_unit(SURR_LOW_FIRST | {6'b0, off[9:0]});
      end
    endcase
  endtask

  task automatic gen_stream();
    int k, n, flaw, at;
    k = $urandom_range(99);
    if (k < 45) begin
      strm = {strm, BYTE_FF, BYTE_FE};
      n    = $urandom_range(1, 4);
      flaw = $urandom_range(9);
      at   = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
        if (i == at && flaw == 2) begin
          push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          push_unit(16'($urandom));
        end
        if (i == at && flaw == 3) push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        push_random_cp();
      end
      if (flaw == 0) strm = {strm, 8'($urandom)};
      if (flaw == 1) push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
    end else if (k < 60) begin
      strm = {strm, BYTE_EF, BYTE_BB, BYTE_BF};
      n = $urandom_range(6);
      repeat (n) strm = {strm, 8'($urandom)};
    end else if (k < 80) begin
      n = $urandom_range(1, 8);
      repeat (n) strm = {strm, 8'($urandom)};
    end else if (k < 90) begin
      case ($urandom_range(5))
        0: strm = '{BYTE_EF};
        1: strm = '{BYTE_EF, BYTE_BB};
        2: strm = '{BYTE_EF, BYTE_BB, 8'($urandom)};
        3: strm = '{BYTE_FE, BYTE_FF};
        4: strm = '{BYTE_FF, BYTE_FE};
        default: strm = '{BYTE_FF};
      endcase
      n = $urandom_range(3);
      repeat (n) strm = {strm, 8'($urandom)};
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) strm = {strm, ($urandom_range(1) ? 8'($urandom_range(8'hFE, 8'hFF))
                                                  : 8'($urandom))};
    end
    end_stream();
  endtask

  task automatic wait_drained();
    while (byte_stim.size() != 0 || s_tvalid || utf8_expected.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin
    int start;
    restart_stream();
    lead0     = 8'h00;
    lead1     = 8'h00;
    unit_lo   = 8'h00;
    high_bits = 10'h000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed streams
    strm = '{BYTE_FF};                          end_stream();
    strm = '{BYTE_EF, BYTE_BB};                 end_stream();
    strm = '{BYTE_FE, BYTE_FF};                 end_stream();
    strm = '{BYTE_FF, BYTE_FE};                 end_stream();
    strm = '{BYTE_FF, BYTE_FE, 8'h00};          end_stream();
    strm = '{BYTE_FF, BYTE_FE, 8'h3D, 8'hD8};   end_stream();
    strm = '{BYTE_FF, BYTE_FE, 8'h3D, 8'hD8, 8'h41, 8'h00, 8'h7F};
    end_stream();
    strm = '{BYTE_FF, BYTE_FE, 8'h00, 8'hDC};   end_stream();
    strm = '{BYTE_FF, BYTE_FE, 8'hAC, 8'h20, 8'h3D, 8'hD8, 8'h00, 8'hDE};
    end_stream();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  hold_go = 1'b1; end
        1: begin sender_idle_pct = 53; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 53; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      start = byte_stim.size();
      while (byte_stim.size() - start < ITEMS_PER_PHASE) gen_stream();
      wait_drained();
    end

    $display("covered %0d streams, %0d input bytes, %0d output items checked",
             streams_sent, bytes_in, items_checked);
    $display("streams ended by an error item: %0d, mismatches: %0d", error_ends, fails);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
